// ----- design/bcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and controller/datapath command and status types
// for the bipartite check block. No dependencies.
package bcb_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;
    localparam int VTX_IN_W         = 10;
    localparam int VCOUNT_W         = 10;

    localparam logic [1:0] COLOUR_NONE = 2'd0;
    localparam logic [1:0] COLOUR_A    = 2'd1;
    localparam logic [1:0] COLOUR_SUM  = 2'd3;

    typedef struct packed {
        logic capture;
        logic drop;
        logic rd_a;
        logic wr_a;
        logic rd_b;
        logic wr_b;
        logic chk_start;
        logic seed_rd;
        logic seed_claim;
        logic seed_next;
        logic pop_rd;
        logic pop_fetch;
        logic head_cap;
        logic link_rd;
        logic link_cap;
        logic col_apply;
        logic set_fail;
        logic res_load;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic fits;
        logic last;
        logic top_zero;
        logic seed_last;
        logic colour_zero;
        logic clash;
        logic queue_empty;
        logic link_end;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/bcb_ifaces.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for edges, results and configuration.
// Depends on bcb_pkg.
interface bcb_edge_if
    import bcb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VTX_IN_W-1:0] edge_from;
    logic [VTX_IN_W-1:0] edge_to;
    logic                last_edge;
    modport source (output valid, edge_from, edge_to, last_edge, input ready);
    modport sink   (input valid, edge_from, edge_to, last_edge, output ready);
endinterface

interface bcb_result_if;
    logic valid;
    logic ready;
    logic is_bipartite;
    logic edge_overflow;
    modport source (output valid, is_bipartite, edge_overflow, input ready);
    modport sink   (input valid, is_bipartite, edge_overflow, output ready);
endinterface

interface bcb_cfg_if
    import bcb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VCOUNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- design/bcb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath: adjacency, colour and queue memories, counters, result register.
// Depends on bcb_pkg; driven by bcb_ctrl commands.
module bcb_datapath
    import bcb_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [VTX_IN_W-1:0] edge_from,
    input  wire logic [VTX_IN_W-1:0] edge_to,
    input  wire logic                last_edge,
    input  wire logic                cfg_valid,
    input  wire logic [VCOUNT_W-1:0] cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     is_bipartite,
    output logic                     edge_overflow
);

    localparam int VW       = $clog2(MAX_VERTICES);
    localparam int QW       = VW + 1;
    localparam int LINK_CAP = 2 * MAX_EDGES;
    localparam int LW       = $clog2(LINK_CAP + 1);
    localparam int LIW      = $clog2(LINK_CAP);

    // memories
    logic [LW-1:0]    head_mem   [MAX_VERTICES];
    logic [1:0]       colour_mem [MAX_VERTICES];
    logic [LW+VW-1:0] link_mem   [LINK_CAP];
    logic [VW-1:0]    queue_mem  [MAX_VERTICES];

    logic [LW-1:0]    head_q;
    logic [1:0]       colour_q;
    logic [LW+VW-1:0] link_q;
    logic [VW-1:0]    queue_q;

    // control registers
    logic [VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [LW-1:0]       links_reg, links_next;
    logic                ovf_reg, ovf_next;
    logic [VW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [QW-1:0]       rd_reg, rd_next;
    logic [QW-1:0]       wr_reg, wr_next;
    logic                ok_reg, ok_next;

    // payload registers
    logic [VW-1:0] a_reg, a_next;
    logic [VW-1:0] b_reg, b_next;
    logic          fit_reg, fit_next;
    logic          last_reg, last_next;
    logic [VW-1:0] top_reg, top_next;
    logic [VW-1:0] seed_reg, seed_next;
    logic [1:0]    cu_reg, cu_next;
    logic [LW-1:0] lk_reg, lk_next;
    logic [VW-1:0] v_reg, v_next;
    logic          res_bip_reg, res_bip_next;
    logic          res_ovf_reg, res_ovf_next;

    logic [31:0] from_w, to_w, links_w, vc_w, top_w;
    logic        enqueue_ok;
    logic        col_new;

    logic          head_we;
    logic [VW-1:0] head_waddr, head_raddr;
    logic [LW-1:0] head_wdata;
    logic          colour_we;
    logic [VW-1:0] colour_waddr, colour_raddr;
    logic [1:0]    colour_wdata;
    logic          link_we;
    logic          queue_we;
    logic [VW-1:0] queue_waddr, queue_wdata;
    logic [VW-1:0] link_tgt;

    assign from_w     = 32'(edge_from);
    assign to_w       = 32'(edge_to);
    assign links_w    = 32'(links_reg);
    assign vc_w       = 32'(vcount_reg);
    assign top_w      = (vc_w > 32'(MAX_VERTICES - 1)) ? 32'(MAX_VERTICES - 1) : vc_w;
    assign link_tgt   = link_q[VW-1:0];
    assign enqueue_ok = 32'(wr_reg) < 32'(MAX_VERTICES);
    assign col_new    = cmd.col_apply && (colour_q == COLOUR_NONE);

    // memory port selection
    always_comb
    begin
        head_we    = cmd.wr_a || cmd.wr_b || cmd.clr_step;
        head_waddr = cmd.clr_step ? clr_reg : (cmd.wr_a ? a_reg : b_reg);
        head_wdata = cmd.clr_step ? LW'(LINK_CAP) : links_reg;
        head_raddr = cmd.rd_a ? a_reg : (cmd.rd_b ? b_reg : queue_q);

        colour_we    = cmd.clr_step || cmd.seed_claim || col_new;
        colour_waddr = cmd.clr_step ? clr_reg : (cmd.seed_claim ? seed_reg : v_reg);
        colour_wdata = cmd.clr_step ? COLOUR_NONE :
                       (cmd.seed_claim ? COLOUR_A : (COLOUR_SUM - cu_reg));
        colour_raddr = cmd.seed_rd ? seed_reg : (cmd.pop_fetch ? queue_q : link_tgt);

        link_we = cmd.wr_a || cmd.wr_b;

        queue_we    = cmd.seed_claim || (col_new && enqueue_ok);
        queue_waddr = cmd.seed_claim ? '0 : wr_reg[VW-1:0];
        queue_wdata = cmd.seed_claim ? seed_reg : v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (colour_we)
        begin
            colour_mem[colour_waddr] <= colour_wdata;
        end
        colour_q <= colour_mem[colour_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[links_reg[LIW-1:0]] <= {head_q, (cmd.wr_a ? b_reg : a_reg)};
        end
        link_q <= link_mem[lk_reg[LIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[queue_waddr] <= queue_wdata;
        end
        queue_q <= queue_mem[rd_reg[VW-1:0]];
    end

    // next-state logic
    always_comb
    begin
        vcount_next    = cfg_valid ? cfg_data : vcount_reg;
        links_next     = links_reg;
        ovf_next       = ovf_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        ok_next        = ok_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        fit_next       = fit_reg;
        last_next      = last_reg;
        top_next       = top_reg;
        seed_next      = seed_reg;
        cu_next        = cu_reg;
        lk_next        = lk_reg;
        v_next         = v_reg;
        res_bip_next   = res_bip_reg;
        res_ovf_next   = res_ovf_reg;

        if (cmd.capture)
        begin
            a_next    = from_w[VW-1:0];
            b_next    = to_w[VW-1:0];
            last_next = last_edge;
            fit_next  = (from_w < 32'(MAX_VERTICES)) && (to_w < 32'(MAX_VERTICES)) &&
                        (links_w + 32'd2 <= 32'(LINK_CAP));
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.wr_a || cmd.wr_b)
        begin
            links_next = links_reg + LW'(1);
        end
        if (cmd.chk_start)
        begin
            top_next  = top_w[VW-1:0];
            seed_next = VW'(1);
            ok_next   = 1'b1;
        end
        if (cmd.seed_next)
        begin
            seed_next = seed_reg + VW'(1);
        end
        if (cmd.seed_claim)
        begin
            rd_next = '0;
            wr_next = QW'(1);
        end
        if (cmd.pop_rd)
        begin
            rd_next = rd_reg + QW'(1);
        end
        if (cmd.head_cap)
        begin
            cu_next = colour_q;
            lk_next = head_q;
        end
        if (cmd.link_cap)
        begin
            v_next  = link_tgt;
            lk_next = link_q[LW+VW-1:VW];
        end
        if (col_new && enqueue_ok)
        begin
            wr_next = wr_reg + QW'(1);
        end
        if (cmd.set_fail)
        begin
            ok_next = 1'b0;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
            res_bip_next   = ok_reg;
            res_ovf_next   = ovf_reg;
            links_next     = '0;
            ovf_next       = 1'b0;
            clr_next       = '0;
        end
        if (cmd.clr_step)
        begin
            clr_next = clr_reg + VW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            links_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            ok_reg        <= 1'b1;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            links_reg     <= links_next;
            ovf_reg       <= ovf_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            ok_reg        <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        fit_reg     <= fit_next;
        last_reg    <= last_next;
        top_reg     <= top_next;
        seed_reg    <= seed_next;
        cu_reg      <= cu_next;
        lk_reg      <= lk_next;
        v_reg       <= v_next;
        res_bip_reg <= res_bip_next;
        res_ovf_reg <= res_ovf_next;
    end

    always_comb
    begin
        sts.fits        = fit_reg;
        sts.last        = last_reg;
        sts.top_zero    = (vcount_reg == '0);
        sts.seed_last   = (seed_reg == top_reg);
        sts.colour_zero = (colour_q == COLOUR_NONE);
        sts.clash       = (colour_q == cu_reg);
        sts.queue_empty = (rd_reg == wr_reg);
        sts.link_end    = (32'(lk_reg) >= 32'(LINK_CAP));
        sts.clr_last    = (32'(clr_reg) == 32'(MAX_VERTICES - 1));
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign is_bipartite  = res_bip_reg;
    assign edge_overflow = res_ovf_reg;

    a_links_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(links_reg) <= 32'(LINK_CAP))
        else $error("link count beyond store capacity");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= wr_reg)
        else $error("queue read pointer passed write pointer");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_link_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_a || cmd.wr_b) |-> (32'(links_reg) < 32'(LINK_CAP)))
        else $error("link written beyond store");

endmodule
`default_nettype wire

// ----- design/bcb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine: edge linking, breadth-first walk, clear sweep.
// Depends on bcb_pkg; commands bcb_datapath.
module bcb_ctrl
    import bcb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LD_CHK   = 4'd1;
    localparam logic [3:0] S_LD_WA    = 4'd2;
    localparam logic [3:0] S_LD_RB    = 4'd3;
    localparam logic [3:0] S_LD_WB    = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_SEED_RD  = 4'd6;
    localparam logic [3:0] S_SEED_TST = 4'd7;
    localparam logic [3:0] S_POP      = 4'd8;
    localparam logic [3:0] S_POP_W    = 4'd9;
    localparam logic [3:0] S_HEAD     = 4'd10;
    localparam logic [3:0] S_LINK     = 4'd11;
    localparam logic [3:0] S_LINK_W   = 4'd12;
    localparam logic [3:0] S_COL      = 4'd13;
    localparam logic [3:0] S_RESULT   = 4'd14;
    localparam logic [3:0] S_CLEAR    = 4'd15;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LD_CHK;
                end
            end
            S_LD_CHK:
            begin
                if (sts.fits)
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_LD_WA;
                end
                else
                begin
                    cmd.drop   = 1'b1;
                    state_next = sts.last ? S_CHECK : S_IDLE;
                end
            end
            S_LD_WA:
            begin
                cmd.wr_a   = 1'b1;
                state_next = S_LD_RB;
            end
            S_LD_RB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_LD_WB;
            end
            S_LD_WB:
            begin
                cmd.wr_b   = 1'b1;
                state_next = sts.last ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                cmd.chk_start = 1'b1;
                state_next    = sts.top_zero ? S_RESULT : S_SEED_RD;
            end
            S_SEED_RD:
            begin
                cmd.seed_rd = 1'b1;
                state_next  = S_SEED_TST;
            end
            S_SEED_TST:
            begin
                if (sts.colour_zero)
                begin
                    cmd.seed_claim = 1'b1;
                    state_next     = S_POP;
                end
                else if (sts.seed_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.seed_next = 1'b1;
                    state_next    = S_SEED_RD;
                end
            end
            S_POP:
            begin
                if (!sts.queue_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_W;
                end
                else if (sts.seed_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.seed_next = 1'b1;
                    state_next    = S_SEED_RD;
                end
            end
            S_POP_W:
            begin
                cmd.pop_fetch = 1'b1;
                state_next    = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.head_cap = 1'b1;
                state_next   = S_LINK;
            end
            S_LINK:
            begin
                state_next = sts.link_end ? S_POP : S_LINK_W;
            end
            S_LINK_W:
            begin
                cmd.link_cap = 1'b1;
                state_next   = S_COL;
            end
            S_COL:
            begin
                cmd.col_apply = 1'b1;
                if (!sts.colour_zero && sts.clash)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_RESULT:
            begin
                // hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_ready_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LD_CHK))
        else $error("accepted edge did not enter the link sequence");

    a_single_store_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_a, cmd.wr_b, cmd.clr_step, cmd.seed_claim, cmd.col_apply}))
        else $error("conflicting store writes");

    a_clear_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_step && sts.clr_last) |=> in_ready)
        else $error("clear sweep did not return to idle");

endmodule
`default_nettype wire

// ----- design/bipartite_check_bfs_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each edge is checked for fit, then dropped or linked (two head reads, two link writes).
// The last edge starts the walk (skipped when the vertex count is zero), which tests seed
// vertices, dequeues vertices and visits their adjacency links; the result is loaded once the
// result register is free. After reset and after each result a sweep over all MAX_VERTICES
// entries clears list heads and colours; no edge is taken during it. Configuration writes are
// taken in any cycle. Depends on bcb_pkg, bcb_ifaces, bcb_datapath, bcb_ctrl.
module bipartite_check_bfs_top
    import bcb_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bcb_edge_if.sink      edges,
    bcb_result_if.source  result,
    bcb_cfg_if.sink       cfg
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign edges.ready = in_ready;
    assign cfg.ready   = 1'b1;

    bcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bcb_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .edge_from     (edges.edge_from),
        .edge_to       (edges.edge_to),
        .last_edge     (edges.last_edge),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .is_bipartite  (result.is_bipartite),
        .edge_overflow (result.edge_overflow)
    );

endmodule
`default_nettype wire

// ----- tb/tb_bipartite_check_bfs_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bipartite_check_bfs_top: streams edge graphs, predicts each
// two-colouring verdict and overflow flag, and checks every result beat in order.
// Depends on bcb_pkg, bcb_ifaces and the block's RTL.
module tb_bipartite_check_bfs_top;
    import bcb_pkg::*;

    localparam int VTX_SLOTS  = DEF_MAX_VERTICES;
    localparam int LINK_SLOTS = 2 * DEF_MAX_EDGES;
    localparam int NO_LINK    = LINK_SLOTS;
    localparam int SETTLE     = DEF_MAX_VERTICES + 100;

    typedef struct packed {
        logic is_bipartite;
        logic edge_overflow;
    } verdict_t;

    logic clk;
    logic rst_n;

    bcb_edge_if   edge_bus();
    bcb_result_if res_bus();
    bcb_cfg_if    cfg_bus();

    bipartite_check_bfs_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .edges  (edge_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    // Shadow of the block's graph store
    logic [13:0]         head_of   [VTX_SLOTS];
    logic [13:0]         next_of   [LINK_SLOTS];
    logic [VTX_IN_W-1:0] target_of [LINK_SLOTS];
    logic [1:0]          shade     [VTX_SLOTS];
    int unsigned         used_links;
    bit                  dropped;
    logic [VCOUNT_W-1:0] vcount_shadow;

    verdict_t verdicts_due[$];
    int       fail_count;
    int       edges_sent;
    int       graphs_checked;
    int       odd_graphs;
    int       overflow_graphs;
    int       burst_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("Timeout at %0t", $realtime);
        $display("Test completed with failures");
        $finish;
    end

    task automatic clear_shadow();
        for (int k = 0; k < VTX_SLOTS; k++)
        begin
            head_of[k] = 14'(NO_LINK);
            shade[k]   = COLOUR_NONE;
        end
        used_links = 0;
        dropped    = 1'b0;
    endtask

    function automatic bit colour_from(int seed);
        int frontier[$];
        int u;
        int lk;
        int v;
        shade[seed] = COLOUR_A;
        frontier = {frontier, seed};
        while (frontier.size() > 0)
        begin
            u  = frontier.pop_front();
            lk = head_of[u];
            while (lk < LINK_SLOTS)
            begin
                v = target_of[lk];
                if (shade[v] == COLOUR_NONE)
                begin
                    shade[v] = COLOUR_SUM - shade[u];
                    frontier = {frontier, v};
                end
                else if (shade[v] == shade[u])
                    return 1'b0;
                lk = next_of[lk];
            end
        end
        return 1'b1;
    endfunction

    // Apply one accepted edge; on the last edge work out the verdict.
    task automatic absorb_edge(input int a, input int b, input bit lst);
        verdict_t vd;
        int       top;
        bit       ok;
        if (used_links + 2 > LINK_SLOTS)
            dropped = 1'b1;
        else
        begin
            target_of[used_links] = VTX_IN_W'(b);
            next_of[used_links]   = head_of[a];
            head_of[a]            = 14'(used_links);
            used_links++;
            target_of[used_links] = VTX_IN_W'(a);
            next_of[used_links]   = head_of[b];
            head_of[b]            = 14'(used_links);
            used_links++;
        end
        if (lst)
        begin
            for (int k = 0; k < VTX_SLOTS; k++)
                shade[k] = COLOUR_NONE;
            top = (vcount_shadow > VTX_SLOTS - 1) ? VTX_SLOTS - 1 : vcount_shadow;
            ok  = 1'b1;
            for (int s = 1; s <= top && ok; s++)
                if (shade[s] == COLOUR_NONE && !colour_from(s))
                    ok = 1'b0;
            vd.is_bipartite  = ok;
            vd.edge_overflow = dropped;
            verdicts_due = {verdicts_due, vd};
            if (!ok)
                odd_graphs++;
            if (dropped)
                overflow_graphs++;
            clear_shadow();
        end
    endtask

    task automatic send_edge(input int a, input int b, input bit lst);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8))
            begin
                @(negedge clk);
                edge_bus.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        edge_bus.valid     <= 1'b1;
        edge_bus.edge_from <= VTX_IN_W'(a);
        edge_bus.edge_to   <= VTX_IN_W'(b);
        edge_bus.last_edge <= lst;
        do
            @(posedge clk);
        while (!edge_bus.ready);
        edges_sent++;
        absorb_edge(a, b, lst);
    endtask

    // Drop valid, wait out every pending verdict, then let the clearing sweep pass.
    task automatic drain();
        @(negedge clk);
        edge_bus.valid <= 1'b0;
        while (verdicts_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int n);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= VCOUNT_W'(n);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        vcount_shadow = VCOUNT_W'(n);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Receiver stalls: runs of always-ready, coin-flip and sparse ready.
    int stall_mode;
    int stall_left;
    int stall_tick;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: res_bus.ready <= 1'b1;
            1: res_bus.ready <= 1'($urandom_range(0, 1));
            default: res_bus.ready <= (stall_tick % 5 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result beat bip=%0b ovf=%0b", $realtime,
                         res_bus.is_bipartite, res_bus.edge_overflow);
                fail_count++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                graphs_checked++;
                if (res_bus.is_bipartite !== want.is_bipartite)
                begin
                    $display("%0t: is_bipartite expected %0b actual %0b", $realtime,
                             want.is_bipartite, res_bus.is_bipartite);
                    fail_count++;
                end
                if (res_bus.edge_overflow !== want.edge_overflow)
                begin
                    $display("%0t: edge_overflow expected %0b actual %0b", $realtime,
                             want.edge_overflow, res_bus.edge_overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_small_graphs();
        // no seeds: always bipartite
        set_vertex_count(0);
        send_edge(1, 2, 1'b0);
        send_edge(2, 1, 1'b1);
        drain();
        // triangle, then square
        set_vertex_count(4);
        send_edge(1, 2, 1'b0);
        send_edge(2, 3, 1'b0);
        send_edge(3, 1, 1'b1);
        send_edge(1, 2, 1'b0);
        send_edge(2, 3, 1'b0);
        send_edge(3, 4, 1'b0);
        send_edge(4, 1, 1'b1);
        drain();
        // self loop, then self loop on an unseeded vertex
        set_vertex_count(5);
        send_edge(5, 5, 1'b1);
        send_edge(9, 9, 1'b1);
        drain();
        // vertex zero closes an odd cycle but never seeds
        set_vertex_count(2);
        send_edge(0, 1, 1'b0);
        send_edge(0, 2, 1'b0);
        send_edge(1, 2, 1'b1);
        send_edge(0, 0, 1'b1);
        drain();
        // top vertex ids with full vertex count
        set_vertex_count(1023);
        send_edge(1023, 1022, 1'b0);
        send_edge(1022, 1, 1'b0);
        send_edge(1023, 1, 1'b1);
        send_edge(1023, 1023, 1'b1);
        drain();
    endtask

    task automatic test_random_graphs();
        int span;
        int n_edges;
        int a;
        int b;
        int graphs;
        graphs = 0;
        while (edges_sent < 460)
        begin
            if (graphs % 4 == 0)
            begin
                drain();
                case ($urandom_range(0, 5))
                    0: set_vertex_count(0);
                    1: set_vertex_count(1023);
                    default: set_vertex_count($urandom_range(1, 40));
                endcase
            end
            span    = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(2, 48);
            n_edges = $urandom_range(1, 20);
            for (int k = 0; k < n_edges; k++)
            begin
                a = $urandom_range(0, span);
                b = $urandom_range(0, span);
                // mostly odd-to-even edges, so most graphs stay two-colourable
                if ($urandom_range(0, 9) != 0)
                    b = (b & ~1) | (~a & 1);
                if (b > 1023)
                    b = 1022;
                send_edge(a, b, k == n_edges - 1);
            end
            graphs++;
        end
        // pure noise graph over the full field range
        for (int k = 0; k < 16; k++)
            send_edge($urandom_range(0, 1023), $urandom_range(0, 1023), k == 15);
        drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        edge_bus.valid     = 1'b0;
        edge_bus.edge_from = '0;
        edge_bus.edge_to   = '0;
        edge_bus.last_edge = 1'b0;
        res_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.data       = '0;
        fail_count         = 0;
        edges_sent         = 0;
        graphs_checked     = 0;
        odd_graphs         = 0;
        overflow_graphs    = 0;
        burst_left         = 0;
        stall_left         = 0;
        stall_tick         = 0;
        vcount_shadow      = '0;
        clear_shadow();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_small_graphs();
        test_random_graphs();

        $display("Sent %0d edges, checked %0d graph verdicts", edges_sent, graphs_checked);
        $display("Graphs not two-colourable: %0d, with dropped edges: %0d",
                 odd_graphs, overflow_graphs);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
design/bcb_pkg.sv
design/bcb_ifaces.sv
design/bcb_datapath.sv
design/bcb_ctrl.sv
design/bipartite_check_bfs_top.sv
tb/tb_bipartite_check_bfs_top.sv
